// ===== sv/bmg_pkg.sv =====
package bmg_pkg;

    // Stage counts
    localparam int CordicSteps = 24;
    localparam int LogRounds   = 24;
    localparam int SqrtBits    = 24;

    // ln(2) in Q0.32
    localparam logic [31:0] Ln2Q32 = 32'd2977044472;
    // CORDIC start value, 1/gain in Q.30
    localparam logic signed [32:0] InvGainQ30 = 33'sd652032874;

    localparam logic signed [23:0] OutMax = 24'sd524287;
    localparam logic signed [23:0] OutMin = -24'sd524288;

    // atan(2^-i) in 2^32-per-turn units
    localparam logic [29:0] TurnAtan [CordicSteps] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    typedef struct packed {
        logic [31:0] uniform_a;
        logic [31:0] uniform_b;
    } t_in;

    typedef struct packed {
        logic signed [19:0] gauss_cos;
        logic signed [19:0] gauss_sin;
    } t_out;

    typedef logic signed [32:0] t_cval;

    // cosine/sine pair in Q.30
    typedef struct packed {
        t_cval c;
        t_cval s;
    } t_trig;

endpackage

// ===== sv/bmg_front.sv =====
module bmg_front import bmg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_in         i_data,
    output logic        o_valid,
    output logic [46:0] o_r2,
    output t_trig       o_trig
);

    // stage 0 registers plus one per log round / CORDIC step
    logic               r_val [0:LogRounds];
    logic [31:0]        r_m   [0:LogRounds];
    logic [23:0]        r_f   [0:LogRounds];
    logic [4:0]         r_e   [0:LogRounds];
    logic [1:0]         r_q   [0:LogRounds];
    logic signed [32:0] r_x   [0:LogRounds];
    logic signed [32:0] r_y   [0:LogRounds];
    logic signed [32:0] r_z   [0:LogRounds];

    logic               r_out_val;
    logic [46:0]        r_r2;
    t_trig              r_trig;

    // normalize u1: clamp zero, find msb, left-justify
    logic [31:0] w_a;
    logic [4:0]  w_e;
    logic [31:0] w_m;

    always_comb begin
        w_a = (i_data.uniform_a == 32'd0) ? 32'd1 : i_data.uniform_a;
        w_e = 5'd0;
        for (int k = 0; k < 32; k++) begin
            if (w_a[k]) begin
                w_e = 5'(k);
            end
        end
        w_m = w_a << (5'd31 - w_e);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val[0] <= 1'b0;
        end else if (i_en) begin
            r_val[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= w_m;
            r_f[0] <= 24'd0;
            r_e[0] <= w_e;
            r_q[0] <= i_data.uniform_b[31:30];
            r_x[0] <= InvGainQ30;
            r_y[0] <= 33'sd0;
            r_z[0] <= $signed({3'b000, i_data.uniform_b[29:0]});
        end
    end

    // one squaring round of the log and one CORDIC step per stage
    for (genvar i = 0; i < LogRounds; i++) begin : g_stage
        logic [63:0]        w_sq;
        logic signed [32:0] w_dx;
        logic signed [32:0] w_dy;
        logic signed [32:0] w_at;

        assign w_sq = 64'(r_m[i]) * 64'(r_m[i]);
        assign w_dx = r_y[i] >>> i;
        assign w_dy = r_x[i] >>> i;
        assign w_at = $signed({3'b000, TurnAtan[i]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[i+1] <= 1'b0;
            end else if (i_en) begin
                r_val[i+1] <= r_val[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[i+1] <= w_sq[63] ? w_sq[63:32] : w_sq[62:31];
                r_f[i+1] <= {r_f[i][22:0], w_sq[63]};
                r_e[i+1] <= r_e[i];
                r_q[i+1] <= r_q[i];
                if (!r_z[i][32]) begin
                    r_x[i+1] <= r_x[i] - w_dx;
                    r_y[i+1] <= r_y[i] + w_dy;
                    r_z[i+1] <= r_z[i] - w_at;
                end else begin
                    r_x[i+1] <= r_x[i] + w_dx;
                    r_y[i+1] <= r_y[i] - w_dy;
                    r_z[i+1] <= r_z[i] + w_at;
                end
            end
        end
    end

    // -log2(u1) in Q6.24, scaled by 2 ln 2 into Q.40
    logic [5:0]  w_k;
    logic [29:0] w_lg;
    logic [61:0] w_prod;
    t_trig       w_trig;

    assign w_k    = 6'd32 - {1'b0, r_e[LogRounds]};
    assign w_lg   = {w_k, 24'd0} - {6'd0, r_f[LogRounds]};
    assign w_prod = 62'(w_lg) * 62'(Ln2Q32);

    // quadrant fold
    always_comb begin
        case (r_q[LogRounds])
            2'd0: begin
                w_trig.c = r_x[LogRounds];
                w_trig.s = r_y[LogRounds];
            end
            2'd1: begin
                w_trig.c = -r_y[LogRounds];
                w_trig.s = r_x[LogRounds];
            end
            2'd2: begin
                w_trig.c = -r_x[LogRounds];
                w_trig.s = -r_y[LogRounds];
            end
            default: begin
                w_trig.c = r_y[LogRounds];
                w_trig.s = -r_x[LogRounds];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_val <= 1'b0;
        end else if (i_en) begin
            r_out_val <= r_val[LogRounds];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r2   <= w_prod[61:15];
            r_trig <= w_trig;
        end
    end

    assign o_valid = r_out_val;
    assign o_r2    = r_r2;
    assign o_trig  = r_trig;

endmodule

// ===== sv/bmg_sqrt.sv =====
module bmg_sqrt import bmg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [46:0] i_r2,
    input  t_trig       i_trig,
    output logic        o_valid,
    output logic [23:0] o_root,
    output t_trig       o_trig
);

    logic        r_val  [0:SqrtBits-1];
    logic [47:0] r_rem  [0:SqrtBits-1];
    logic [23:0] r_root [0:SqrtBits-1];
    t_trig       r_trig [0:SqrtBits-1];

    // restoring square root, one result bit per stage, msb first
    for (genvar k = 0; k < SqrtBits; k++) begin : g_bit
        localparam int Bit = SqrtBits - 1 - k;

        logic        w_val;
        logic [47:0] w_rem;
        logic [23:0] w_root;
        t_trig       w_trig;
        logic [47:0] w_try;

        if (k == 0) begin : g_first
            assign w_val  = i_valid;
            assign w_rem  = {1'b0, i_r2};
            assign w_root = 24'd0;
            assign w_trig = i_trig;
        end else begin : g_next
            assign w_val  = r_val[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_trig = r_trig[k-1];
        end

        assign w_try = (48'(w_root) << (Bit + 1)) + (48'd1 << (2 * Bit));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[k] <= 1'b0;
            end else if (i_en) begin
                r_val[k] <= w_val;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_trig[k] <= w_trig;
                if (w_rem >= w_try) begin
                    r_rem[k]  <= w_rem - w_try;
                    r_root[k] <= w_root | (24'd1 << Bit);
                end else begin
                    r_rem[k]  <= w_rem;
                    r_root[k] <= w_root;
                end
            end
        end
    end

    assign o_valid = r_val[SqrtBits-1];
    assign o_root  = r_root[SqrtBits-1];
    assign o_trig  = r_trig[SqrtBits-1];

endmodule

// ===== sv/box_muller_gaussian.sv =====
// Channel   Direction  Handshake                  Beat
// input     in         i_in_valid / o_in_ready    t_in  (uniform_a, uniform_b)
// output    out        o_out_valid / i_out_ready  t_out (gauss_cos, gauss_sin)
//
// One beat in and one beat out per cycle while the skid register is empty. Stages:
// normalize (1), log squaring rounds in step with CORDIC (24), log scaling multiply (1),
// square root bit stages (24), radius multiply (1), output register (1).
// Synchronous active-low reset clears only valid bits.
// A stalled output parks one beat in a skid register; the pipeline holds while it is full.
module box_muller_gaussian import bmg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic        w_en;
    logic        w_fr_val;
    logic [46:0] w_fr_r2;
    t_trig       w_fr_trig;
    logic        w_sq_val;
    logic [23:0] w_sq_root;
    t_trig       w_sq_trig;

    logic               r_mul_val;
    logic signed [57:0] r_pc;
    logic signed [57:0] r_ps;
    logic               r_skid_val;
    t_out               r_skid;
    logic               r_out_val;
    t_out               r_out;

    // pipeline advances while the skid register is empty
    assign w_en       = !r_skid_val;
    assign o_in_ready = w_en;

    bmg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (w_fr_val),
        .o_r2    (w_fr_r2),
        .o_trig  (w_fr_trig)
    );

    bmg_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fr_val),
        .i_r2    (w_fr_r2),
        .i_trig  (w_fr_trig),
        .o_valid (w_sq_val),
        .o_root  (w_sq_root),
        .o_trig  (w_sq_trig)
    );

    // radius times cosine and sine
    logic signed [24:0] w_r;
    assign w_r = $signed({1'b0, w_sq_root});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_val <= 1'b0;
        end else if (w_en) begin
            r_mul_val <= w_sq_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pc <= 58'(w_r) * 58'(w_sq_trig.c);
            r_ps <= 58'(w_r) * 58'(w_sq_trig.s);
        end
    end

    // round half up to Q.16 and saturate
    function automatic logic signed [19:0] to_field(input logic signed [57:0] p);
        logic signed [57:0] v;
        logic signed [23:0] t;
        v = p + 58'sd8589934592;
        t = v[57:34];
        if (t > OutMax) begin
            t = OutMax;
        end else if (t < OutMin) begin
            t = OutMin;
        end
        return t[19:0];
    endfunction

    t_out w_res;
    assign w_res.gauss_cos = to_field(r_pc);
    assign w_res.gauss_sin = to_field(r_ps);

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_val  <= 1'b0;
            r_skid_val <= 1'b0;
        end else if (!r_out_val || i_out_ready) begin
            if (r_skid_val) begin
                r_out_val  <= 1'b1;
                r_skid_val <= 1'b0;
            end else begin
                r_out_val  <= r_mul_val;
            end
        end else if (w_en && r_mul_val) begin
            r_skid_val <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_val || i_out_ready) begin
            r_out <= r_skid_val ? r_skid : w_res;
        end else if (w_en && r_mul_val) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid = r_out_val;
    assign o_out_data  = r_out;

endmodule

// ===== tb/sv/tb_box_muller_gaussian.sv =====
`timescale 1ns / 1ps

module tb_box_muller_gaussian;
    import bmg_pkg::*;

    localparam int PipeDepth  = 52;
    localparam int CycleLimit = 400000;

    // atan(2^-i) in 2^32-per-turn units
    localparam longint AngleStep [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    t_out   pending_pairs[$];
    int     error_count;
    int     beats_sent;
    int     beats_seen;
    int     cycle_count;
    int     long_hold;
    logic   busy_rx;

    box_muller_gaussian DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // shift rounding toward minus infinity
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [19:0] scale_sat(longint r, longint t);
        longint v;
        v = shr_floor(r * t + (longint'(1) << 33), 34);
        if (v > 524287) v = 524287;
        if (v < -524288) v = -524288;
        return v[19:0];
    endfunction

    // expected normal pair for one uniform pair
    function automatic t_out gauss_pair(t_in u);
        logic [63:0] a, m, f, lg, r2;
        int          e;
        longint      r, x, y, z, dx, dy, c, s;
        logic [1:0]  quad;
        t_out        o;
        a = {32'd0, u.uniform_a};
        if (a == 0) a = 1;
        e = 31;
        while (a[e] == 1'b0) e--;
        m = a << (31 - e);
        f = 0;
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 31;
            f = f << 1;
            if (m >= (64'd1 << 32)) begin
                f[0] = 1'b1;
                m = m >> 1;
            end
        end
        lg = (64'(32 - e) << 24) - f;
        r2 = (lg * 64'd2977044472) >> 15;
        r  = longint'(isqrt64(r2));
        quad = u.uniform_b[31:30];
        z = longint'(u.uniform_b[29:0]);
        x = 652032874;
        y = 0;
        for (int i = 0; i < 24; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= AngleStep[i];
            end else begin
                x += dx; y -= dy; z += AngleStep[i];
            end
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        o.gauss_cos = scale_sat(r, c);
        o.gauss_sin = scale_sat(r, s);
        return o;
    endfunction

    // send one uniform pair; valid held until accepted
    task automatic push_uniform(logic [31:0] ua, logic [31:0] ub);
        t_in d;
        d.uniform_a = ua;
        d.uniform_b = ub;
        i_in_valid <= 1'b1;
        i_in_data  <= d;
        do @(posedge i_clk); while (!o_in_ready);
        pending_pairs.push_back(gauss_pair(d));
        beats_sent++;
    endtask

    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drop_valid();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // field extremes, zero clamp, every quadrant boundary
    task automatic test_directed();
        logic [31:0] edge_a [6] = '{32'd0, 32'd1, 32'd2, 32'h8000_0000,
                                    32'hFFFF_FFFF, 32'h5555_5555};
        logic [31:0] edge_b [10] = '{32'd0, 32'h4000_0000, 32'h8000_0000,
                                     32'hC000_0000, 32'hFFFF_FFFF, 32'h3FFF_FFFF,
                                     32'h2000_0000, 32'hAAAA_AAAA, 32'h7FFF_FFFF,
                                     32'h0000_0001};
        for (int i = 0; i < 6; i++) push_uniform(edge_a[i], edge_b[i]);
        for (int i = 6; i < 10; i++) push_uniform(32'd1, edge_b[i]);
        for (int i = 0; i < 6; i++) push_uniform(edge_a[i], 32'hFFFF_FFFF - edge_a[i]);
        drop_valid();
    endtask

    // random pairs in bursts with gaps; sizes of a spread over all exponents
    task automatic test_random(int count);
        logic [31:0] ua;
        for (int i = 0; i < count; i++) begin
            ua = $urandom();
            if ($urandom_range(0, 2) == 0) ua = ua >> $urandom_range(0, 31);
            push_uniform(ua, $urandom());
            idle_gap();
        end
        drop_valid();
    endtask

    // receiver holds off long while sender keeps offering
    task automatic test_backpressure(int count);
        long_hold = 200;
        for (int i = 0; i < count; i++) push_uniform($urandom(), $urandom());
        drop_valid();
    endtask

    // receiver stall pattern, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            busy_rx     <= 1'b0;
        end else if (long_hold > 0) begin
            i_out_ready <= 1'b0;
            long_hold   <= long_hold - 1;
        end else begin
            if ($urandom_range(0, 15) == 0) busy_rx <= ~busy_rx;
            i_out_ready <= busy_rx ? ($urandom_range(0, 3) == 0) : 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_seen <= beats_seen + 1;
            if (pending_pairs.size() == 0) begin
                $display("%0t: unexpected beat, actual cos=%0d sin=%0d", $time,
                         o_out_data.gauss_cos, o_out_data.gauss_sin);
                error_count++;
            end else begin
                want = pending_pairs.pop_front();
                if (o_out_data.gauss_cos !== want.gauss_cos) begin
                    $display("%0t: gauss_cos expected %0d actual %0d", $time,
                             want.gauss_cos, o_out_data.gauss_cos);
                    error_count++;
                end
                if (o_out_data.gauss_sin !== want.gauss_sin) begin
                    $display("%0t: gauss_sin expected %0d actual %0d", $time,
                             want.gauss_sin, o_out_data.gauss_sin);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cycle_count > CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        beats_sent  = 0;
        beats_seen  = 0;
        cycle_count = 0;
        long_hold   = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure(120);
        test_random(820);

        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (PipeDepth + 10) @(posedge i_clk);
        if (pending_pairs.size() != 0) error_count++;

        $display("Sent %0d uniform pairs (edges, quadrant limits, long stall, random);",
                 beats_sent);
        $display("checked %0d normal pairs, %0d mismatches.", beats_seen, error_count);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
